// File: design/atc_pkg.sv
// Shared constants and types for the four-channel arrival-time capture block.
package atc_pkg;

    localparam int TIME_W     = 32;
    localparam int LIMIT_W    = 16;
    localparam int HOLD_W     = LIMIT_W + 1;
    localparam int COUNT_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0]    COUNT_MAX          = 8'd255;
    localparam logic [COUNT_W-1:0]    ARRIVALS_TO_VALID  = 8'd4;
    localparam logic [CFG_DATA_W-1:0] WINDOW_HIGH_RESET  = 16'h09B1;
    localparam logic [CFG_DATA_W-1:0] WINDOW_LOW_RESET   = 16'h064D;
    localparam logic [LIMIT_W-1:0]    HOLDOFF_RESET      = 16'd30000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_HIGH   = 2'd0,
        CFG_WINDOW_LOW    = 2'd1,
        CFG_HOLDOFF_LIMIT = 2'd2
    } cfg_index_t;

endpackage

// File: design/atc_if.sv
// Handshake channels for scans in and capture results out.
interface atc_scan_if #(
    parameter int CHANNELS    = 4,
    parameter int SAMPLE_BITS = 12
);
    logic                              valid;
    logic                              ready;
    logic [CHANNELS*SAMPLE_BITS-1:0]   sample_ch;
    logic [atc_pkg::TIME_W-1:0]        time_now;

    modport source (output valid, output sample_ch, output time_now, input ready);
    modport sink   (input valid, input sample_ch, input time_now, output ready);
endinterface

interface atc_result_if #(
    parameter int CHANNELS = 4
);
    localparam int FIRED_W = $clog2(CHANNELS + 1);

    logic                                  valid;
    logic                                  ready;
    logic [FIRED_W-1:0]                    fired_channel;
    logic                                  times_valid;
    logic [CHANNELS*atc_pkg::TIME_W-1:0]   arrival_ch;
    logic [atc_pkg::COUNT_W-1:0]           arrivals_seen;

    modport source (output valid, output fired_channel, output times_valid,
                    output arrival_ch, output arrivals_seen, input ready);
    modport sink   (input valid, input fired_channel, input times_valid,
                    input arrival_ch, input arrivals_seen, output ready);
endinterface

// File: design/four_channel_arrival_time_capture.sv
// Top level of the four-channel arrival-time capture block.
//
// One scan (a sample per channel and the free-running time base) is accepted
// per clock cycle while the result side takes each result. A scan is held
// in an input register, then a single stage of window compares, a
// lowest-channel priority pick, one 32-bit elapsed-time subtract and the
// holdoff counter update produces the result, which is kept in the capture
// state registers themselves. Throughput is one scan per cycle whenever the
// result side takes each result; a stalled result holds the state and the
// input register, and at most one further scan is taken meanwhile. Arrival
// times are measured from the first trigger of a round; the fourth trigger
// of a round freezes the timer and raises times_valid. Configuration writes
// are taken at any cycle.
module four_channel_arrival_time_capture #(
    parameter int CHANNELS    = 4,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [atc_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [atc_pkg::CFG_DATA_W-1:0]    wr_data,
    atc_scan_if.sink                          scan,
    atc_result_if.source                      result
);
    import atc_pkg::*;

    localparam int FIRED_W  = $clog2(CHANNELS + 1);
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Configuration
    logic [SAMPLE_BITS-1:0] window_high_reg;
    logic [SAMPLE_BITS-1:0] window_low_reg;
    logic [LIMIT_W-1:0]     holdoff_limit_reg;

    // Input register
    logic                            s1_valid_reg;
    logic [CHANNELS*SAMPLE_BITS-1:0] s1_sample_reg;
    logic [TIME_W-1:0]               s1_time_reg;

    // Result and capture state
    logic                   res_valid_reg;
    logic [FIRED_W-1:0]     fired_reg;
    logic [FIRED_W-1:0]     fired_next;
    logic [COUNT_W-1:0]     arrival_count_reg;
    logic [COUNT_W-1:0]     arrival_count_next;
    logic [TIME_W-1:0]      arrival_time_reg [CHANNELS];
    logic                   valid_flag_reg;
    logic                   valid_flag_next;
    logic                   timer_running_reg;
    logic                   timer_running_next;
    logic [TIME_W-1:0]      timer_origin_reg;
    logic [TIME_W-1:0]      timer_origin_next;
    logic [TIME_W-1:0]      frozen_elapsed_reg;
    logic [TIME_W-1:0]      frozen_elapsed_next;

    logic                   advance;
    logic [CHANNELS-1:0]    outside;
    logic [CHANNELS-1:0]    past;
    logic [CHANNELS-1:0]    eligible;
    logic [CHANNELS-1:0]    clear;
    logic                   all_past_next;
    logic                   found;
    logic [CH_IDX_W-1:0]    winner;
    logic [TIME_W-1:0]      elapsed;
    logic [TIME_W-1:0]      stamp;
    logic [COUNT_W-1:0]     count_inc;
    logic                   round_done;
    logic [SAMPLE_BITS-1:0] smp;

    // Move the held scan on when the result slot is free or being emptied
    assign advance     = s1_valid_reg && (!res_valid_reg || result.ready);
    assign scan.ready  = !s1_valid_reg || advance;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_high_reg   <= WINDOW_HIGH_RESET[SAMPLE_BITS-1:0];
            window_low_reg    <= WINDOW_LOW_RESET[SAMPLE_BITS-1:0];
            holdoff_limit_reg <= HOLDOFF_RESET;
        end
        else if (wr_en)
        begin
            case (cfg_index_t'(wr_index))
                CFG_WINDOW_HIGH:   window_high_reg   <= wr_data[SAMPLE_BITS-1:0];
                CFG_WINDOW_LOW:    window_low_reg    <= wr_data[SAMPLE_BITS-1:0];
                CFG_HOLDOFF_LIMIT: holdoff_limit_reg <= wr_data[LIMIT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (scan.ready)
        begin
            s1_valid_reg <= scan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan.valid && scan.ready)
        begin
            s1_sample_reg <= scan.sample_ch;
            s1_time_reg   <= scan.time_now;
        end
    end

    atc_holdoff #(
        .CHANNELS (CHANNELS)
    ) u_holdoff (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .clear         (clear),
        .limit         (holdoff_limit_reg),
        .past          (past),
        .all_past_next (all_past_next)
    );

    // Window test per channel
    always_comb
    begin
        smp = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            smp        = s1_sample_reg[c*SAMPLE_BITS +: SAMPLE_BITS];
            outside[c] = (smp > window_high_reg) || (smp < window_low_reg);
        end
    end

    assign eligible = outside & past;

    // Pick the lowest numbered eligible channel
    always_comb
    begin
        found  = 1'b0;
        winner = '0;
        for (int c = CHANNELS - 1; c >= 0; c--)
        begin
            if (eligible[c])
            begin
                found  = 1'b1;
                winner = CH_IDX_W'(c);
            end
        end
        for (int c = 0; c < CHANNELS; c++)
        begin
            clear[c] = found && (winner == CH_IDX_W'(c));
        end
    end

    // Timing and round bookkeeping
    always_comb
    begin
        elapsed   = timer_running_reg ? s1_time_reg - timer_origin_reg : frozen_elapsed_reg;
        stamp     = (arrival_count_reg == '0) ? '0 : elapsed;
        count_inc = arrival_count_reg;
        if (found && arrival_count_reg != COUNT_MAX)
        begin
            count_inc = arrival_count_reg + COUNT_W'(1);
        end
        round_done = found && (count_inc == ARRIVALS_TO_VALID);

        timer_origin_next   = timer_origin_reg;
        timer_running_next  = timer_running_reg;
        frozen_elapsed_next = frozen_elapsed_reg;
        valid_flag_next     = valid_flag_reg;
        if (found)
        begin
            valid_flag_next = round_done;
            if (arrival_count_reg == '0)
            begin
                timer_origin_next  = s1_time_reg;
                timer_running_next = 1'b1;
            end
        end
        if (round_done)
        begin
            frozen_elapsed_next = stamp;
            timer_running_next  = 1'b0;
        end

        arrival_count_next = all_past_next ? '0 : count_inc;
        fired_next         = found ? FIRED_W'(winner) : FIRED_W'(CHANNELS);
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Capture state, which also forms the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fired_reg          <= '0;
            arrival_count_reg  <= '0;
            valid_flag_reg     <= 1'b0;
            timer_running_reg  <= 1'b0;
            timer_origin_reg   <= '0;
            frozen_elapsed_reg <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                arrival_time_reg[c] <= '0;
            end
        end
        else if (advance)
        begin
            fired_reg          <= fired_next;
            arrival_count_reg  <= arrival_count_next;
            valid_flag_reg     <= valid_flag_next;
            timer_running_reg  <= timer_running_next;
            timer_origin_reg   <= timer_origin_next;
            frozen_elapsed_reg <= frozen_elapsed_next;
            if (found)
            begin
                arrival_time_reg[winner] <= stamp;
            end
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.fired_channel = fired_reg;
    assign result.times_valid   = valid_flag_reg;
    assign result.arrivals_seen = arrival_count_reg;

    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_arrival
        assign result.arrival_ch[g*TIME_W +: TIME_W] = arrival_time_reg[g];
    end

    // A completed round has stopped the timer
    a_valid_stops_timer: assert property (
        @(posedge clk) disable iff (!rst_n)
        valid_flag_reg |-> !timer_running_reg
    ) else $error("times_valid set while the timer runs");

    // A completed round leaves the count at the round length or cleared
    a_valid_count: assert property (
        @(posedge clk) disable iff (!rst_n)
        valid_flag_reg |-> (arrival_count_reg == ARRIVALS_TO_VALID)
                        || (arrival_count_reg == '0)
    ) else $error("times_valid set with an unexpected arrival count");

    // Capture state moves only when a scan advances
    a_state_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(arrival_count_reg) && $stable(valid_flag_reg)
                     && $stable(fired_reg) && $stable(timer_origin_reg)
    ) else $error("capture state changed without a scan");

endmodule

// File: design/atc_holdoff.sv
// Per-channel holdoff counters with saturation and the all-past-limit test.
module atc_holdoff #(
    parameter int CHANNELS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [CHANNELS-1:0]           clear,
    input  logic [atc_pkg::LIMIT_W-1:0]   limit,
    output logic [CHANNELS-1:0]           past,
    output logic                          all_past_next
);
    import atc_pkg::*;

    logic [HOLD_W-1:0] count_reg  [CHANNELS];
    logic [HOLD_W-1:0] count_next [CHANNELS];
    logic [HOLD_W-1:0] cap;
    logic [HOLD_W-1:0] base;

    assign cap = {1'b0, limit} + HOLD_W'(1);

    // Flag channels whose holdoff has run out
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            past[c] = count_reg[c] > {1'b0, limit};
        end
    end

    // Clear the winner, then count up towards the cap
    always_comb
    begin
        base          = '0;
        all_past_next = 1'b1;
        for (int c = 0; c < CHANNELS; c++)
        begin
            base = clear[c] ? '0 : count_reg[c];
            count_next[c] = (base < cap) ? base + HOLD_W'(1) : base;
            if (count_next[c] <= {1'b0, limit})
            begin
                all_past_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                count_reg[c] <= '0;
            end
        end
        else if (advance)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                count_reg[c] <= count_next[c];
            end
        end
    end

endmodule

// File: tb/tb.sv
// Testbench for the four-channel arrival-time capture block, with its predictor.
`timescale 1ns / 100ps

import atc_pkg::*;

typedef struct packed {
    logic [2:0]       fired;
    logic             times_valid;
    logic [3:0][31:0] arrival;
    logic [7:0]       seen;
} capture_t;

class capture_scoreboard;
    localparam logic [2:0] NO_WINNER = 3'd4;

    // register copies
    logic [11:0] win_high;
    logic [11:0] win_low;
    logic [15:0] hold_limit;

    // capture state
    logic [16:0] hold_cnt [4];
    logic [7:0]  arr_cnt;
    logic [31:0] arr_time [4];
    logic        times_ok;
    logic        running;
    logic [31:0] origin;
    logic [31:0] frozen;

    capture_t expected_captures [$];
    int       errors;

    function new();
        win_high   = WINDOW_HIGH_RESET[11:0];
        win_low    = WINDOW_LOW_RESET[11:0];
        hold_limit = HOLDOFF_RESET;
        for (int c = 0; c < 4; c++)
        begin
            hold_cnt[c] = '0;
            arr_time[c] = '0;
        end
        arr_cnt  = '0;
        times_ok = 1'b0;
        running  = 1'b0;
        origin   = '0;
        frozen   = '0;
        errors   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_WINDOW_HIGH:   win_high = data[11:0];
            CFG_WINDOW_LOW:    win_low = data[11:0];
            CFG_HOLDOFF_LIMIT: hold_limit = data;
            default:           ;
        endcase
    endfunction

    function logic [31:0] elapsed(logic [31:0] now);
        return running ? now - origin : frozen;
    endfunction

    // Work out the capture that one accepted scan produces and queue it.
    function void note_scan(logic [47:0] samples, logic [31:0] now);
        logic [2:0]  winner;
        logic [16:0] cap;
        logic [11:0] s;
        bit          all_past;
        capture_t    exp_cap;
        winner   = NO_WINNER;
        cap      = {1'b0, hold_limit} + 17'd1;
        all_past = 1'b1;

        // pick the lowest eligible channel
        for (int c = 0; c < 4; c++)
        begin
            s = samples[c*12 +: 12];
            if (winner == NO_WINNER && (s > win_high || s < win_low)
                && hold_cnt[c] > {1'b0, hold_limit})
                winner = 3'(c);
        end

        // handle the arrival
        if (winner != NO_WINNER)
        begin
            hold_cnt[winner[1:0]] = '0;
            times_ok = 1'b0;
            if (arr_cnt == 8'd0)
            begin
                origin = now;
                running = 1'b1;
                arr_time[winner[1:0]] = '0;
            end
            else
                arr_time[winner[1:0]] = elapsed(now);
            if (arr_cnt < COUNT_MAX)
                arr_cnt = arr_cnt + 8'd1;
            if (arr_cnt == 8'd4)
            begin
                frozen = elapsed(now);
                running = 1'b0;
                times_ok = 1'b1;
            end
        end

        // advance holdoff counters, clear the round once all are past
        for (int c = 0; c < 4; c++)
        begin
            if (hold_cnt[c] < cap)
                hold_cnt[c] = hold_cnt[c] + 17'd1;
            if (hold_cnt[c] <= {1'b0, hold_limit})
                all_past = 1'b0;
        end
        if (all_past)
            arr_cnt = '0;

        exp_cap.fired       = winner;
        exp_cap.times_valid = times_ok;
        for (int c = 0; c < 4; c++)
            exp_cap.arrival[c] = arr_time[c];
        exp_cap.seen = arr_cnt;
        expected_captures.push_back(exp_cap);
    endfunction

    task report(string what);
        $display("[%0t] mismatch: %s", $time, what);
        errors++;
    endtask

    task check_capture(capture_t got);
        capture_t exp_cap;
        if (expected_captures.size() == 0)
        begin
            report("capture with nothing expected");
            return;
        end
        exp_cap = expected_captures.pop_front();
        if (got.fired !== exp_cap.fired)
            report($sformatf("fired_channel got %0d exp %0d", got.fired, exp_cap.fired));
        if (got.times_valid !== exp_cap.times_valid)
            report($sformatf("times_valid got %0b exp %0b",
                             got.times_valid, exp_cap.times_valid));
        for (int c = 0; c < 4; c++)
            if (got.arrival[c] !== exp_cap.arrival[c])
                report($sformatf("arrival_ch%0d got %h exp %h",
                                 c, got.arrival[c], exp_cap.arrival[c]));
        if (got.seen !== exp_cap.seen)
            report($sformatf("arrivals_seen got %0d exp %0d", got.seen, exp_cap.seen));
    endtask

    function int pending();
        return expected_captures.size();
    endfunction
endclass

module tb;
    localparam int                   CYCLE_LIMIT = 200000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    atc_scan_if #(.CHANNELS(4), .SAMPLE_BITS(12)) scan_ch ();
    atc_result_if #(.CHANNELS(4)) result_ch ();

    four_channel_arrival_time_capture #(
        .CHANNELS    (4),
        .SAMPLE_BITS (12)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .scan     (scan_ch),
        .result   (result_ch)
    );

    capture_scoreboard board = new();
    bit                calm = 1'b0;
    logic [31:0]       time_base = 32'd0;
    int                cycles = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // result side: check each taken item, stall in bursts
    initial
    begin
        int       stall_left;
        capture_t got;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                got.fired       = result_ch.fired_channel;
                got.times_valid = result_ch.times_valid;
                got.arrival     = result_ch.arrival_ch;
                got.seen        = result_ch.arrivals_seen;
                board.check_capture(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Offer one scan, idling first at random, and hold it until taken.
    task automatic push_scan(logic [47:0] samples, logic [31:0] now);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            scan_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        scan_ch.valid     <= 1'b1;
        scan_ch.sample_ch <= samples;
        scan_ch.time_now  <= now;
        do
            @(posedge clk);
        while (!scan_ch.ready);
        board.note_scan(samples, now);
    endtask

    task automatic send(logic [11:0] s0, logic [11:0] s1, logic [11:0] s2,
                        logic [11:0] s3, logic [31:0] now);
        push_scan({s3, s2, s1, s0}, now);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        board.set_reg(idx, data);
    endtask

    // Write all registers; window data carries random bits above 12.
    task automatic configure(logic [11:0] hi, logic [11:0] lo, logic [15:0] lim,
                             bit poke_unused);
        write_reg(CFG_WINDOW_HIGH, {4'($urandom), hi});
        write_reg(CFG_WINDOW_LOW, {4'($urandom), lo});
        write_reg(CFG_HOLDOFF_LIMIT, lim);
        if (poke_unused)
            write_reg(CFG_UNUSED, 16'($urandom));
        wr_en <= 1'b0;
    endtask

    // Drop valid and wait for every expected capture, plus pipeline slack.
    task automatic settle();
        scan_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [11:0] pick_sample(bit outside);
        bit can_hi;
        bit can_lo;
        can_hi = board.win_high < 12'd4095;
        can_lo = board.win_low > 12'd0;
        if (!outside)
            return 12'($urandom_range(board.win_high, board.win_low));
        if (can_hi && (!can_lo || $urandom_range(0, 1) == 1))
            return 12'($urandom_range(4095, board.win_high + 1));
        if (can_lo)
            return 12'($urandom_range(board.win_low - 1, 0));
        return 12'($urandom_range(4095, 0));
    endfunction

    function automatic logic [31:0] next_time();
        case ($urandom_range(0, 15))
            0:       time_base = $urandom();
            1:       time_base = 32'hFFFF_FFFF - $urandom_range(0, 40);
            default: time_base = time_base + $urandom_range(1, 300);
        endcase
        return time_base;
    endfunction

    // One setting, then random scans; the tail of the last phase runs calm.
    task automatic run_phase(logic [11:0] hi, logic [11:0] lo, logic [15:0] lim,
                             bit poke_unused, int n, int p_out, int calm_tail);
        logic [47:0] samples;
        configure(hi, lo, lim, poke_unused);
        for (int i = 0; i < n; i++)
        begin
            if (i >= n - calm_tail)
                calm = 1'b1;
            if ($urandom_range(0, 7) == 0)
                samples = 48'({$urandom(), $urandom()});
            else
                for (int c = 0; c < 4; c++)
                    samples[c*12 +: 12] = pick_sample($urandom_range(1, 100) <= p_out);
            push_scan(samples, next_time());
        end
        settle();
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        wr_en             <= 1'b0;
        wr_index          <= CFG_WINDOW_HIGH;
        wr_data           <= '0;
        scan_ch.valid     <= 1'b0;
        scan_ch.sample_ch <= '0;
        scan_ch.time_now  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: field extremes and window edges, nothing may fire yet
        send(12'd0, 12'd0, 12'd0, 12'd0, 32'h0000_0000);
        send(12'd4095, 12'd4095, 12'd4095, 12'd4095, 32'hFFFF_FFFF);
        send(12'd2481, 12'd2482, 12'd1613, 12'd1612, 32'h5555_AAAA);
        send(12'd2482, 12'd1612, 12'd4095, 12'd0, 32'hAAAA_5555);
        settle();

        // one full round across the time wrap, then arrivals past the fourth
        configure(12'd2481, 12'd1613, 16'd1, 1'b0);
        send(12'd4095, 12'd2000, 12'd2000, 12'd2000, 32'hFFFF_FFF0);
        send(12'd2481, 12'd0, 12'd2000, 12'd2000, 32'hFFFF_FFFA);
        send(12'd1613, 12'd2000, 12'd2482, 12'd2000, 32'h0000_0005);
        send(12'd2000, 12'd2000, 12'd2000, 12'd1612, 32'h0000_0100);
        send(12'd4095, 12'd4095, 12'd4095, 12'd4095, 32'h0000_0200);
        send(12'd0, 12'd0, 12'd0, 12'd0, 32'h0000_0300);
        send(12'd2000, 12'd2000, 12'd2000, 12'd2000, 32'h0000_0400);
        send(12'd2000, 12'd2000, 12'd2000, 12'd2000, 32'h0000_0500);
        send(12'd2000, 12'd2000, 12'd2000, 12'd2000, 32'h0000_0600);
        settle();

        // random phases over several settings
        run_phase(12'd2481, 12'd1613, 16'd3, 1'b1, 80, 60, 0);
        run_phase(12'd4095, 12'd0, 16'd0, 1'b0, 15, 50, 0);
        run_phase(12'd2000, 12'd2000, 16'd0, 1'b1, 20, 50, 0);
        run_phase(12'd0, 12'd4095, 16'd3, 1'b0, 280, 100, 0);
        run_phase(12'($urandom), 12'($urandom), 16'hFFFF, 1'b1, 20, 50, 0);
        run_phase(12'($urandom_range(3000, 1800)), 12'($urandom_range(1800, 1000)),
                  16'($urandom_range(12, 1)), 1'b0, 60, 50, 40);

        repeat (10) @(posedge clk);
        if (board.pending() != 0)
            board.report("captures still expected at the end");
        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
